FILE: rtl/core/set_associative_lru_cache_model_assert.svh
// ----------------------------------------------------------------------------
// set associative lru cache model assertion macros
// shared assertion forms for the cache core, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef SET_ASSOCIATIVE_LRU_CACHE_MODEL_ASSERT_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_MODEL_ASSERT_SVH

// same-cycle implication
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// geometry, row and candidate types and the lru pick for the cache core
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int SETS    = 1024;
    localparam int WAYS    = 16;
    localparam int ADDR_W  = 48;
    localparam int SHIFT_W = 4;
    localparam int WAY_W   = 4;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LVLS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LVL_W   = (LVLS > 1) ? $clog2(LVLS) : 1;
    localparam int WAYS_P2 = 1 << LVLS;
    localparam int OUT_W   = ((1 + WAY_W + 2 * ADDR_W + 7) / 8) * 8;

    localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(6);
    localparam logic [ADDR_W-1:0]  CNT_MAX   = {ADDR_W{1'b1}};

    // one set of the cache as stored in the memory
    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0][ADDR_W-1:0] tag;
        logic [WAYS-1:0][ADDR_W-1:0] stamp;
    } t_row;

    // lru tree candidate
    typedef struct packed {
        logic              present;
        logic [WAY_W-1:0]  idx;
        logic [ADDR_W-1:0] stamp;
    } t_cand;

    // older stamp wins, left (lower way) wins ties
    function automatic t_cand pick(input t_cand a, input t_cand b);
        t_cand r;
        r = (b.present && (!a.present || (b.stamp < a.stamp))) ? b : a;
        return r;
    endfunction

endpackage

FILE: rtl/core/set_associative_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_associative_lru_cache_model
// set-associative cache lookup with lru fill, one result item per address
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                 | payload
//  s_axis   | in  | tvalid / tready           | tdata[47:0] address
//  m_axis   | out | tvalid / tready           | tdata: hit, way, hit_total, miss_total
//  cfg      | in  | we (write on edge)        | wdata[3:0] line_shift
//
//  an item passes accept/read, tag compare and write-back on a hit or when the set
//  has a free way, and runs the lru tree before write-back when it has none.
//  the rate is set by the single read-modify-write of the set memory per item.
//  after reset a clearing pass writes all SETS rows, one per cycle, before the
//  first item is taken.
//  a stalled result holds the write-back; no new item is taken while it waits.
// ----------------------------------------------------------------------------
`include "set_associative_lru_cache_model_assert.svh"

module set_associative_lru_cache_model
    import salc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [ADDR_W-1:0]  i_s_axis_tdata,   // address
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [OUT_W-1:0]   o_m_axis_tdata,   // hit, way, hit_total, miss_total, zero pad
    input  logic               i_cfg_we,
    input  logic [SHIFT_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_TREE,
        S_WRITE
    } t_state;

    t_state               r_state;
    logic [SET_W-1:0]     r_clr_addr;
    logic [SHIFT_W-1:0]   r_line_shift;
    logic [ADDR_W-1:0]    r_line;
    logic [SET_W-1:0]     r_set;
    logic                 r_hit;
    logic [WAY_W-1:0]     r_way;
    logic [LVL_W-1:0]     r_lvl;
    logic [ADDR_W-1:0]    r_acc;
    logic [ADDR_W-1:0]    r_hit_cnt;
    logic [ADDR_W-1:0]    r_miss_cnt;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;
    t_cand                r_cand [WAYS_P2];
    t_row                 r_rd_row;

    t_row                 mem [SETS];

    logic                 s_fire;
    logic                 out_free;
    logic [ADDR_W-1:0]    line_in;
    logic [SET_W-1:0]     set_in;
    logic                 mem_we;
    logic [SET_W-1:0]     mem_waddr;
    t_row                 mem_wdata;
    t_row                 n_row;
    logic [ADDR_W-1:0]    n_acc;
    logic [ADDR_W-1:0]    n_hit_cnt;
    logic [ADDR_W-1:0]    n_miss_cnt;
    logic                 hit_any;
    logic [WAY_W-1:0]     hit_way;
    logic                 inv_any;
    logic [WAY_W-1:0]     inv_way;
    t_cand                n_cand [WAYS_P2];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign line_in = i_s_axis_tdata >> r_line_shift;
    assign set_in  = line_in[SET_W-1:0];

    // tag compare: first matching way, and the last free way in scan order
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rd_row.valid[w] && (r_rd_row.tag[w] == r_line)) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (!r_rd_row.valid[w]) begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
    end

    // one level of the lru tree per cycle
    always_comb begin
        for (int i = 0; i < WAYS_P2; i++) begin
            n_cand[i] = r_cand[i];
        end
        for (int i = 0; i < WAYS_P2 / 2; i++) begin
            n_cand[i] = pick(r_cand[2 * i], r_cand[2 * i + 1]);
        end
    end

    always_comb begin
        n_acc      = r_acc + ADDR_W'(1);
        n_hit_cnt  = (r_hit && (r_hit_cnt != CNT_MAX)) ? r_hit_cnt + ADDR_W'(1) : r_hit_cnt;
        n_miss_cnt = (!r_hit && (r_miss_cnt != CNT_MAX)) ? r_miss_cnt + ADDR_W'(1)
                                                          : r_miss_cnt;
        n_row = r_rd_row;
        n_row.valid[r_way[IDX_W-1:0]] = 1'b1;
        n_row.tag[r_way[IDX_W-1:0]]   = r_line;
        n_row.stamp[r_way[IDX_W-1:0]] = n_acc;
    end

    assign mem_we    = (r_state == S_CLEAR) || ((r_state == S_WRITE) && out_free);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_set;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : n_row;

    // set memory, one row per set, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (s_fire) begin
            r_rd_row <= mem[set_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_line_shift <= SHIFT_RST;
            r_acc        <= '0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_line_shift <= i_cfg_wdata;
            end
            // in write-back the output register is reloaded below
            if (r_out_valid && i_m_axis_tready && (r_state != S_WRITE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + SET_W'(1);
                    if (r_clr_addr == SET_W'(SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        r_line  <= line_in;
                        r_set   <= set_in;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hit <= hit_any;
                    if (hit_any) begin
                        r_way   <= hit_way;
                        r_state <= S_WRITE;
                    end else if (inv_any) begin
                        r_way   <= inv_way;
                        r_state <= S_WRITE;
                    end else begin
                        for (int i = 0; i < WAYS_P2; i++) begin
                            r_cand[i].present <= (i < WAYS);
                            r_cand[i].idx     <= WAY_W'(i);
                            r_cand[i].stamp   <= (i < WAYS) ? r_rd_row.stamp[i] : '0;
                        end
                        r_lvl   <= '0;
                        r_state <= S_TREE;
                    end
                end
                S_TREE: begin
                    for (int i = 0; i < WAYS_P2; i++) begin
                        r_cand[i] <= n_cand[i];
                    end
                    r_lvl <= r_lvl + LVL_W'(1);
                    if (r_lvl == LVL_W'(LVLS - 1)) begin
                        r_way   <= n_cand[0].idx;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (out_free) begin
                        r_acc       <= n_acc;
                        r_hit_cnt   <= n_hit_cnt;
                        r_miss_cnt  <= n_miss_cnt;
                        r_out_valid <= 1'b1;
                        r_out_data  <= {(OUT_W - 1 - WAY_W - 2 * ADDR_W)'(0),
                                        n_miss_cnt, n_hit_cnt, r_way, r_hit};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SALC_ASSERT_NOW(a_no_accept_in_clear, r_state == S_CLEAR, !o_s_axis_tready, "item in clear")
    `SALC_ASSERT_NOW(a_no_rw_overlap, s_fire, !mem_we, "set read overlaps write-back")
    `SALC_ASSERT_NOW(a_way_in_range, r_state == S_WRITE, r_way <= WAY_W'(WAYS - 1), "bad way")
    `SALC_ASSERT_NEXT(a_write_loads_out, (r_state == S_WRITE) && out_free, o_m_axis_tvalid, "no result")

endmodule
